[rtl/crt_pkg.sv]
`default_nettype none

package crt_pkg;

    localparam int BUFFER_BYTES = 128;
    localparam int NODE_SLOTS   = 128;
    localparam int SLOT_COUNT   = 2 * NODE_SLOTS;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
    localparam int BYTE_W       = 8;
    localparam int LANES        = 8;
    localparam int LANE_W       = $clog2(LANES);
    localparam int ROWS         = (BUFFER_BYTES + LANES - 1) / LANES;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int ADDR_W       = LANE_W + ROW_W;
    localparam int BANK_W       = SLOT_W + ROW_W;
    localparam int BANK_DEPTH   = 2 ** BANK_W;
    localparam int MAX_EMIT     = 128;
    localparam int CMP_W        = 10;
    localparam int CRC_BYTES    = 2;
    localparam int TLEN_W       = 8;
    localparam int NODE_W       = 7;
    localparam int TYPE_W       = 16;
    localparam int TID_W        = 5;
    localparam int PAY_W        = 3;
    localparam int CNT_W        = 4;
    localparam int DATA_W       = 64;

    localparam int TAIL_SOT     = 7;
    localparam int TAIL_EOT     = 6;
    localparam int TAIL_TOG     = 5;

    localparam logic [TYPE_W-1:0] TYPE_A_RESET = 16'd1034;
    localparam logic [TYPE_W-1:0] TYPE_B_RESET = 16'd1030;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic REG_TYPE_A = 1'b0;
    localparam logic REG_TYPE_B = 1'b1;

    typedef struct packed {
        logic              frame_extended;
        logic [28:0]       frame_id;
        logic [3:0]        frame_length;
        logic [DATA_W-1:0] frame_data;
    } frame_t;

    typedef struct packed {
        logic              channel;
        logic [NODE_W-1:0] source_node;
        logic [DATA_W-1:0] beat_data;
        logic [CNT_W-1:0]  beat_bytes;
        logic              beat_last;
        logic [TLEN_W-1:0] transfer_length;
    } beat_t;

    typedef struct packed {
        logic [TYPE_W-1:0] type_a;
        logic [TYPE_W-1:0] type_b;
    } cfg_t;

    typedef struct packed {
        logic             active;
        logic [TID_W-1:0] tid;
        logic             toggle;
        logic [LEN_W-1:0] length;
    } meta_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } meta_rd_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        meta_t             data;
    } meta_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  base;
        logic [PAY_W-1:0]  count;
        logic [DATA_W-1:0] data;
    } buf_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  pos;
    } buf_rd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_META,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

endpackage

`default_nettype wire

[rtl/crt_cfg.sv]
`default_nettype none

module crt_cfg
    import crt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [TYPE_W-1:0] type_a_reg;
    logic [TYPE_W-1:0] type_b_reg;
    logic              wr_go;

    assign pready = 1'b1;
    assign wr_go  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_a_reg <= TYPE_A_RESET;
            type_b_reg <= TYPE_B_RESET;
        end
        else if (wr_go)
        begin
            case (paddr[REG_SEL_BIT])
                REG_TYPE_A: type_a_reg <= pwdata[TYPE_W-1:0];
                REG_TYPE_B: type_b_reg <= pwdata[TYPE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_TYPE_A: prdata = APB_DATA_W'(type_a_reg);
            REG_TYPE_B: prdata = APB_DATA_W'(type_b_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.type_a = type_a_reg;
    assign cfg.type_b = type_b_reg;

endmodule

`default_nettype wire

[rtl/crt_meta.sv]
`default_nettype none

module crt_meta
    import crt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire meta_rd_t rd,
    input  wire meta_wr_t wr,
    output meta_t         rd_data
);

    meta_t                 meta_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    meta_t                 q_reg;
    logic                  q_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            meta_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            q_reg <= meta_mem[rd.addr];
        end
    end

    // slots never written read as the reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                q_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

`default_nettype wire

[rtl/crt_buf.sv]
`default_nettype none

module crt_buf
    import crt_pkg::*;
(
    input  wire logic              clk,
    input  wire buf_wr_t           wr,
    input  wire buf_rd_t           rd,
    output logic      [DATA_W-1:0] rd_data
);

    logic [BYTE_W-1:0] lane_q [LANES];
    logic [LANE_W-1:0] pos_lo_reg;

    // one byte lane per bank, byte address a lives in bank a mod 8, row a / 8
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        logic [BYTE_W-1:0] bank_mem [BANK_DEPTH];
        logic [BYTE_W-1:0] q_reg;
        logic [LANE_W-1:0] wr_off;
        logic [LANE_W-1:0] rd_off;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [BYTE_W-1:0] wr_byte;

        assign wr_off  = LANE_W'(j) - wr.base[LANE_W-1:0];
        assign rd_off  = LANE_W'(j) - rd.pos[LANE_W-1:0];
        assign wr_addr = ADDR_W'(wr.base) + ADDR_W'(wr_off);
        assign rd_addr = ADDR_W'(rd.pos) + ADDR_W'(rd_off);
        assign wr_en   = wr.en && (wr_off < wr.count);
        assign wr_byte = wr.data[{wr_off, 3'b000} +: BYTE_W];

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                bank_mem[{wr.slot, wr_addr[ADDR_W-1:LANE_W]}] <= wr_byte;
            end
            if (rd.en)
            begin
                q_reg <= bank_mem[{rd.slot, rd_addr[ADDR_W-1:LANE_W]}];
            end
        end

        assign lane_q[j] = q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            pos_lo_reg <= rd.pos[LANE_W-1:0];
        end
    end

    // rotate banks back into word order
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            rd_data[k*BYTE_W +: BYTE_W] = lane_q[LANE_W'(pos_lo_reg + LANE_W'(k))];
        end
    end

endmodule

`default_nettype wire

[rtl/crt_ctrl.sv]
`default_nettype none

module crt_ctrl
    import crt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              frame_valid,
    output logic                   frame_stall,
    input  wire frame_t            frame,
    output logic                   beat_valid,
    input  wire logic              beat_stall,
    output beat_t                  beat,
    input  wire cfg_t              cfg,
    output meta_rd_t               meta_rd,
    output meta_wr_t               meta_wr,
    input  wire meta_t             meta_q,
    output buf_wr_t                buf_wr,
    output buf_rd_t                buf_rd,
    input  wire logic [DATA_W-1:0] buf_q
);

    state_t            state_reg;
    state_t            state_next;
    frame_t            frame_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              ch_reg;
    logic [NODE_W-1:0] src_reg;
    logic [BYTE_W-1:0] tail_reg;
    logic [PAY_W-1:0]  pay_reg;
    logic [LEN_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  left_reg;
    logic [TLEN_W-1:0] tlen_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              last_reg;
    beat_t             beat_reg;
    beat_t             beat_next;
    logic              beat_valid_reg;
    logic              beat_valid_next;

    // frame decode
    logic [TYPE_W-1:0] dec_type;
    logic [NODE_W-1:0] dec_src;
    logic              dec_hit_a;
    logic              dec_hit_b;
    logic [3:0]        dec_len;
    logic [PAY_W-1:0]  dec_tail_idx;
    logic [BYTE_W-1:0] dec_tail;
    logic              dec_keep;
    logic [SLOT_W-1:0] dec_slot;

    // slot update
    logic              upd_sot;
    logic              upd_eot;
    logic              upd_tog;
    logic [TID_W-1:0]  upd_tid;
    logic [LEN_W:0]    upd_sum;
    logic              upd_fits;
    logic              upd_mismatch;
    logic [LEN_W-1:0]  upd_len;
    meta_t             upd_meta;
    logic              upd_buf_go;
    logic [LEN_W-1:0]  upd_base;
    logic              upd_emit;
    logic [LEN_W-1:0]  upd_pos;
    logic [LEN_W-1:0]  upd_count;
    logic [LEN_W-1:0]  upd_n;

    logic              out_free;
    logic              beat_load;
    logic [DATA_W-1:0] beat_data_masked;

    always_comb
    begin
        dec_type     = frame_reg.frame_id[23:8];
        dec_src      = frame_reg.frame_id[NODE_W-1:0];
        dec_hit_a    = dec_type == cfg.type_a;
        dec_hit_b    = dec_type == cfg.type_b;
        dec_len      = (frame_reg.frame_length > 4'd8) ? 4'd8 : frame_reg.frame_length;
        dec_tail_idx = PAY_W'(dec_len - 4'd1);
        dec_tail     = frame_reg.frame_data[{dec_tail_idx, 3'b000} +: BYTE_W];
        dec_keep     = frame_reg.frame_extended && !frame_reg.frame_id[7]
                       && (dec_hit_a || dec_hit_b)
                       && ({1'b0, dec_src} < 8'(NODE_SLOTS))
                       && (dec_len != 4'd0);
        dec_slot     = SLOT_W'(dec_src) + (dec_hit_a ? SLOT_W'(0) : SLOT_W'(NODE_SLOTS));
    end

    always_comb
    begin
        upd_sot      = tail_reg[TAIL_SOT];
        upd_eot      = tail_reg[TAIL_EOT];
        upd_tog      = tail_reg[TAIL_TOG];
        upd_tid      = tail_reg[TID_W-1:0];
        upd_sum      = (LEN_W+1)'(meta_q.length) + (LEN_W+1)'(pay_reg);
        upd_fits     = upd_sum <= (LEN_W+1)'(BUFFER_BYTES);
        upd_mismatch = !meta_q.active || (upd_tid != meta_q.tid)
                       || (upd_tog != meta_q.toggle);
        upd_len      = upd_fits ? LEN_W'(upd_sum) : meta_q.length;
        upd_meta     = meta_q;
        upd_buf_go   = 1'b0;
        upd_base     = '0;
        upd_emit     = 1'b0;
        upd_pos      = '0;
        upd_count    = '0;
        if (upd_sot)
        begin
            upd_meta.active = !upd_eot;
            upd_meta.tid    = upd_tid;
            upd_meta.toggle = 1'b1;
            upd_meta.length = LEN_W'(pay_reg);
            upd_buf_go      = 1'b1;
            upd_emit        = upd_eot;
            upd_count       = LEN_W'(pay_reg);
        end
        else if (upd_mismatch)
        begin
            upd_meta.active = 1'b0;
        end
        else
        begin
            upd_meta.active = !upd_eot;
            upd_meta.toggle = !meta_q.toggle;
            upd_meta.length = upd_len;
            upd_buf_go      = upd_fits;
            upd_base        = meta_q.length;
            upd_emit        = upd_eot;
            // strip the leading transfer crc
            if (upd_len >= LEN_W'(CRC_BYTES))
            begin
                upd_pos   = LEN_W'(CRC_BYTES);
                upd_count = upd_len - LEN_W'(CRC_BYTES);
            end
            else
            begin
                upd_count = upd_len;
            end
        end
        upd_n = (CMP_W'(upd_count) > CMP_W'(MAX_EMIT)) ? LEN_W'(MAX_EMIT) : upd_count;
    end

    assign out_free = !beat_valid_reg || !beat_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:   state_next = dec_keep ? ST_META : ST_IDLE;
            ST_META:    state_next = upd_emit ? ST_EMIT_RD : ST_IDLE;
            ST_EMIT_RD: state_next = out_free ? ST_EMIT_WR : ST_EMIT_RD;
            ST_EMIT_WR: state_next = last_reg ? ST_IDLE : ST_EMIT_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        frame_stall  = state_reg != ST_IDLE;
        meta_rd.en   = (state_reg == ST_CHECK) && dec_keep;
        meta_rd.addr = dec_slot;
        meta_wr.en   = state_reg == ST_META;
        meta_wr.addr = slot_reg;
        meta_wr.data = upd_meta;
        buf_wr.en    = (state_reg == ST_META) && upd_buf_go;
        buf_wr.slot  = slot_reg;
        buf_wr.base  = upd_base;
        buf_wr.count = pay_reg;
        buf_wr.data  = frame_reg.frame_data;
        buf_rd.en    = (state_reg == ST_EMIT_RD) && out_free;
        buf_rd.slot  = slot_reg;
        buf_rd.pos   = pos_reg;
        beat_load    = state_reg == ST_EMIT_WR;
    end

    // lanes past the byte count read as zero
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            beat_data_masked[k*BYTE_W +: BYTE_W] =
                (CNT_W'(k) < cnt_reg) ? buf_q[k*BYTE_W +: BYTE_W] : '0;
        end
    end

    always_comb
    begin
        beat_next                 = beat_reg;
        beat_valid_next           = beat_valid_reg;
        if (beat_valid_reg && !beat_stall)
        begin
            beat_valid_next = 1'b0;
        end
        if (beat_load)
        begin
            beat_next.channel         = ch_reg;
            beat_next.source_node     = src_reg;
            beat_next.beat_data       = beat_data_masked;
            beat_next.beat_bytes      = cnt_reg;
            beat_next.beat_last       = last_reg;
            beat_next.transfer_length = tlen_reg;
            beat_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            beat_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            beat_valid_reg <= beat_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
        if (frame_valid && !frame_stall)
        begin
            frame_reg <= frame;
        end
        if (state_reg == ST_CHECK)
        begin
            slot_reg <= dec_slot;
            ch_reg   <= !dec_hit_a;
            src_reg  <= dec_src;
            tail_reg <= dec_tail;
            pay_reg  <= dec_tail_idx;
        end
        if ((state_reg == ST_META) && upd_emit)
        begin
            pos_reg  <= upd_pos;
            left_reg <= upd_n;
            tlen_reg <= TLEN_W'(upd_n);
        end
        else if (buf_rd.en)
        begin
            pos_reg  <= pos_reg + LEN_W'(LANES);
            left_reg <= (left_reg > LEN_W'(LANES)) ? left_reg - LEN_W'(LANES) : '0;
        end
        if (buf_rd.en)
        begin
            cnt_reg  <= (left_reg > LEN_W'(LANES)) ? CNT_W'(LANES) : CNT_W'(left_reg);
            last_reg <= !(left_reg > LEN_W'(LANES));
        end
    end

    assign beat_valid = beat_valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

[rtl/can_transfer_reassembler.sv]
// flow: an accepted frame passes CHECK and, if kept, META; a completing frame then emits
//   its words (1 to 16) through EMIT_RD and EMIT_WR, since the buffer bank read is registered;
//   EMIT_RD waits while the output is stalled, and no new frame is taken until back in IDLE
// reset: control and per-slot state cleared at once through valid bits, the
//   buffer banks are not cleared and need no clearing pass
`default_nettype none

module can_transfer_reassembler
    import crt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  frame_valid,
    output logic                       frame_stall,
    input  wire frame_t                frame,
    output logic                       beat_valid,
    input  wire logic                  beat_stall,
    output beat_t                      beat,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t              cfg;
    meta_rd_t          meta_rd;
    meta_wr_t          meta_wr;
    meta_t             meta_q;
    buf_wr_t           buf_wr;
    buf_rd_t           buf_rd;
    logic [DATA_W-1:0] buf_q;

    crt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crt_meta u_meta (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (meta_rd),
        .wr      (meta_wr),
        .rd_data (meta_q)
    );

    crt_buf u_buf (
        .clk     (clk),
        .wr      (buf_wr),
        .rd      (buf_rd),
        .rd_data (buf_q)
    );

    crt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .beat_valid  (beat_valid),
        .beat_stall  (beat_stall),
        .beat        (beat),
        .cfg         (cfg),
        .meta_rd     (meta_rd),
        .meta_wr     (meta_wr),
        .meta_q      (meta_q),
        .buf_wr      (buf_wr),
        .buf_rd      (buf_rd),
        .buf_q       (buf_q)
    );

endmodule

`default_nettype wire

[rtl/crt_checker.sv]
`default_nettype none

module crt_checker
    import crt_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  frame_valid,
    input wire logic  frame_stall,
    input wire logic  beat_valid,
    input wire logic  beat_stall,
    input wire beat_t beat
);

    a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        beat_valid && beat_stall |=> beat_valid && $stable(beat))
        else $error("stalled word changed");

    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall |=> frame_stall)
        else $error("frame taken while busy");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        beat_valid && !beat.beat_last |-> beat.beat_bytes == 4'd8)
        else $error("short word before end of transfer");

    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        beat_valid && beat.beat_last
        |-> beat.transfer_length[2:0] == beat.beat_bytes[2:0])
        else $error("last word count disagrees with transfer length");

endmodule

bind can_transfer_reassembler crt_checker u_crt_checker (.*);

`default_nettype wire
